/* design/sti_pkg.sv */
// Shared types and constants for the segment-triangle intersection pipeline.
// No dependencies; every design module file refers to it by scoped names.
`default_nettype none

package sti_pkg;

    // Item operation codes
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_TEST = 1'b1
    } op_t;

    // Coordinates per point
    localparam int NUM_AXES = 3;

    // Dot-product lanes: determinant, the two scaled barycentric terms and the scaled segment parameter
    localparam int NUM_DOTS = 4;
    localparam int DOT_DET  = 0;
    localparam int DOT_NU   = 1;
    localparam int DOT_NV   = 2;
    localparam int DOT_NT   = 3;

    // Register stages from item acceptance up to and including the result register
    localparam int STAGE_COUNT = 8;

endpackage

`default_nettype wire

/* design/sti_item_if.sv */
// Input channel of the intersection block: handshake, operation and three points.
// Depends on nothing; the coordinate width is a parameter of the interface.
`default_nettype none

interface sti_item_if #(
    parameter int COORD_WIDTH = 24
) ();

    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic signed [COORD_WIDTH-1:0] v0_x;
    logic signed [COORD_WIDTH-1:0] v0_y;
    logic signed [COORD_WIDTH-1:0] v0_z;
    logic signed [COORD_WIDTH-1:0] v1_x;
    logic signed [COORD_WIDTH-1:0] v1_y;
    logic signed [COORD_WIDTH-1:0] v1_z;
    logic signed [COORD_WIDTH-1:0] v2_x;
    logic signed [COORD_WIDTH-1:0] v2_y;
    logic signed [COORD_WIDTH-1:0] v2_z;

    modport source (
        output valid, operation,
        output v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
        input  ready
    );

    modport sink (
        input  valid, operation,
        input  v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
        output ready
    );

endinterface

`default_nettype wire

/* design/sti_result_if.sv */
// Result channel of the intersection block: handshake and the hit bit.
// Depends on nothing.
`default_nettype none

interface sti_result_if ();

    logic valid;
    logic ready;
    logic hit;

    modport source (
        output valid, hit,
        input  ready
    );

    modport sink (
        input  valid, hit,
        output ready
    );

endinterface

`default_nettype wire

/* design/segment_triangle_intersect.sv */
// Segment-triangle intersection block: exact Moller-Trumbore test in integers.
// Item channel: a load beat (operation 0) stores the segment start (v0) and end (v1)
// and produces no result; a test beat (operation 1) checks the stored segment
// against triangle v0, v1, v2 and produces one hit bit on the result channel.
// A test result is offered after its item has passed through eight register stages
// (difference stage, two cross-product stages, three dot-product stages, sign-correction
// stage, result register). Throughput: one item per cycle while the result channel does not stall;
// load beats take no pipeline slot and may be mixed freely with tests.
// A zero determinant reports no hit; crossings on an edge, a vertex or the segment
// end count as hits, a crossing at the segment start does not.
// Reset clears all valid bits and sets the stored segment to the origin, so a
// test before any load reports no hit.
// When the receiver stalls, the result register holds its beat and each stage
// keeps accepting until it is full; items still flow into empty stages, and
// ready drops only when every stage holds a test.
// Depends on sti_pkg, sti_item_if, sti_result_if and the sti_* section modules.
`default_nettype none

module segment_triangle_intersect #(
    parameter int COORD_WIDTH = 24
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    sti_item_if.sink      item,
    sti_result_if.source  result
);

    localparam int DIFF_W  = COORD_WIDTH + 1;
    localparam int CROSS_W = 2 * DIFF_W + 1;
    localparam int DOT_W   = DIFF_W + CROSS_W + 2;

    logic signed [COORD_WIDTH-1:0] va [sti_pkg::NUM_AXES];
    logic signed [COORD_WIDTH-1:0] vb [sti_pkg::NUM_AXES];
    logic signed [COORD_WIDTH-1:0] vc [sti_pkg::NUM_AXES];

    logic                      f_valid;
    logic                      c_ready;
    logic signed [DIFF_W-1:0]  f_dir [sti_pkg::NUM_AXES];
    logic signed [DIFF_W-1:0]  f_e1  [sti_pkg::NUM_AXES];
    logic signed [DIFF_W-1:0]  f_e2  [sti_pkg::NUM_AXES];
    logic signed [DIFF_W-1:0]  f_s   [sti_pkg::NUM_AXES];

    logic                      c_valid;
    logic                      d_ready;
    logic signed [DIFF_W-1:0]  c_dir [sti_pkg::NUM_AXES];
    logic signed [DIFF_W-1:0]  c_e1  [sti_pkg::NUM_AXES];
    logic signed [DIFF_W-1:0]  c_e2  [sti_pkg::NUM_AXES];
    logic signed [DIFF_W-1:0]  c_s   [sti_pkg::NUM_AXES];
    logic signed [CROSS_W-1:0] c_h   [sti_pkg::NUM_AXES];
    logic signed [CROSS_W-1:0] c_q   [sti_pkg::NUM_AXES];

    logic                      d_valid;
    logic                      e_ready;
    logic signed [DOT_W-1:0]   d_sums [sti_pkg::NUM_DOTS];

    // Gather the point coordinates
    assign va[0] = item.v0_x;
    assign va[1] = item.v0_y;
    assign va[2] = item.v0_z;
    assign vb[0] = item.v1_x;
    assign vb[1] = item.v1_y;
    assign vb[2] = item.v1_z;
    assign vc[0] = item.v2_x;
    assign vc[1] = item.v2_y;
    assign vc[2] = item.v2_z;

    sti_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (item.valid),
        .in_ready     (item.ready),
        .in_operation (item.operation),
        .va           (va),
        .vb           (vb),
        .vc           (vc),
        .out_valid    (f_valid),
        .out_ready    (c_ready),
        .dir          (f_dir),
        .e1           (f_e1),
        .e2           (f_e2),
        .s            (f_s)
    );

    sti_cross #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (c_ready),
        .dir_in    (f_dir),
        .e1_in     (f_e1),
        .e2_in     (f_e2),
        .s_in      (f_s),
        .out_valid (c_valid),
        .out_ready (d_ready),
        .dir_out   (c_dir),
        .e1_out    (c_e1),
        .e2_out    (c_e2),
        .s_out     (c_s),
        .h         (c_h),
        .q         (c_q)
    );

    sti_dot #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_valid),
        .in_ready  (d_ready),
        .dir       (c_dir),
        .e1        (c_e1),
        .e2        (c_e2),
        .s         (c_s),
        .h         (c_h),
        .q         (c_q),
        .out_valid (d_valid),
        .out_ready (e_ready),
        .sums      (d_sums)
    );

    sti_decide #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_decide (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d_valid),
        .in_ready  (e_ready),
        .sums      (d_sums),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .hit       (result.hit)
    );

endmodule

`default_nettype wire

/* design/sti_front.sv */
// Front stage: holds the stored segment and forms the edge and offset vectors.
// Depends on sti_pkg.
`default_nettype none

module sti_front #(
    parameter int  COORD_WIDTH = 24,
    localparam int DIFF_W      = COORD_WIDTH + 1
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output      logic                          in_ready,
    input  wire logic                          in_operation,
    input  wire logic signed [COORD_WIDTH-1:0] va [sti_pkg::NUM_AXES],
    input  wire logic signed [COORD_WIDTH-1:0] vb [sti_pkg::NUM_AXES],
    input  wire logic signed [COORD_WIDTH-1:0] vc [sti_pkg::NUM_AXES],
    output      logic                          out_valid,
    input  wire logic                          out_ready,
    output      logic signed [DIFF_W-1:0]      dir [sti_pkg::NUM_AXES],
    output      logic signed [DIFF_W-1:0]      e1  [sti_pkg::NUM_AXES],
    output      logic signed [DIFF_W-1:0]      e2  [sti_pkg::NUM_AXES],
    output      logic signed [DIFF_W-1:0]      s   [sti_pkg::NUM_AXES]
);

    logic signed [COORD_WIDTH-1:0] start_reg [sti_pkg::NUM_AXES];
    logic signed [COORD_WIDTH-1:0] end_reg   [sti_pkg::NUM_AXES];
    logic                          valid_reg;
    logic                          valid_next;
    logic                          advance;
    logic                          load_beat;
    logic                          test_beat;
    logic signed [DIFF_W-1:0]      dir_reg  [sti_pkg::NUM_AXES];
    logic signed [DIFF_W-1:0]      e1_reg   [sti_pkg::NUM_AXES];
    logic signed [DIFF_W-1:0]      e2_reg   [sti_pkg::NUM_AXES];
    logic signed [DIFF_W-1:0]      s_reg    [sti_pkg::NUM_AXES];
    logic signed [DIFF_W-1:0]      dir_next [sti_pkg::NUM_AXES];
    logic signed [DIFF_W-1:0]      e1_next  [sti_pkg::NUM_AXES];
    logic signed [DIFF_W-1:0]      e2_next  [sti_pkg::NUM_AXES];
    logic signed [DIFF_W-1:0]      s_next   [sti_pkg::NUM_AXES];

    // Stage takes a beat when empty or when its contents move on
    assign advance   = !valid_reg || out_ready;
    assign in_ready  = advance;
    assign load_beat = in_valid && advance
                       && (sti_pkg::op_t'(in_operation) == sti_pkg::OP_LOAD);
    assign test_beat = in_valid && advance
                       && (sti_pkg::op_t'(in_operation) == sti_pkg::OP_TEST);

    // Store the segment end points on a load beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sti_pkg::NUM_AXES; i++)
            begin
                start_reg[i] <= '0;
                end_reg[i]   <= '0;
            end
        end
        else if (load_beat)
        begin
            for (int i = 0; i < sti_pkg::NUM_AXES; i++)
            begin
                start_reg[i] <= va[i];
                end_reg[i]   <= vb[i];
            end
        end
    end

    // Form direction, triangle edges and start offset, one bit wider than a coordinate
    always_comb
    begin
        for (int i = 0; i < sti_pkg::NUM_AXES; i++)
        begin
            dir_next[i] = DIFF_W'(end_reg[i]) - DIFF_W'(start_reg[i]);
            e1_next[i]  = DIFF_W'(vb[i]) - DIFF_W'(va[i]);
            e2_next[i]  = DIFF_W'(vc[i]) - DIFF_W'(va[i]);
            s_next[i]   = DIFF_W'(start_reg[i]) - DIFF_W'(va[i]);
        end
    end

    // Only test beats occupy the pipeline
    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = test_beat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (test_beat)
        begin
            dir_reg <= dir_next;
            e1_reg  <= e1_next;
            e2_reg  <= e2_next;
            s_reg   <= s_next;
        end
    end

    assign out_valid = valid_reg;
    assign dir       = dir_reg;
    assign e1        = e1_reg;
    assign e2        = e2_reg;
    assign s         = s_reg;

endmodule

`default_nettype wire

/* design/sti_cross.sv */
// Cross-product section: h = dir x e2 and q = s x e1 over two register stages.
// Depends on sti_pkg.
`default_nettype none

module sti_cross #(
    parameter int  COORD_WIDTH = 24,
    localparam int DIFF_W      = COORD_WIDTH + 1,
    localparam int PROD_W      = 2 * DIFF_W,
    localparam int CROSS_W     = PROD_W + 1
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output      logic                     in_ready,
    input  wire logic signed [DIFF_W-1:0] dir_in [sti_pkg::NUM_AXES],
    input  wire logic signed [DIFF_W-1:0] e1_in  [sti_pkg::NUM_AXES],
    input  wire logic signed [DIFF_W-1:0] e2_in  [sti_pkg::NUM_AXES],
    input  wire logic signed [DIFF_W-1:0] s_in   [sti_pkg::NUM_AXES],
    output      logic                     out_valid,
    input  wire logic                     out_ready,
    output      logic signed [DIFF_W-1:0] dir_out [sti_pkg::NUM_AXES],
    output      logic signed [DIFF_W-1:0] e1_out  [sti_pkg::NUM_AXES],
    output      logic signed [DIFF_W-1:0] e2_out  [sti_pkg::NUM_AXES],
    output      logic signed [DIFF_W-1:0] s_out   [sti_pkg::NUM_AXES],
    output      logic signed [CROSS_W-1:0] h      [sti_pkg::NUM_AXES],
    output      logic signed [CROSS_W-1:0] q      [sti_pkg::NUM_AXES]
);

    logic                      c1_valid_reg;
    logic                      c2_valid_reg;
    logic                      c1_advance;
    logic                      c2_advance;
    logic signed [PROD_W-1:0]  ha_next [sti_pkg::NUM_AXES];
    logic signed [PROD_W-1:0]  hb_next [sti_pkg::NUM_AXES];
    logic signed [PROD_W-1:0]  qa_next [sti_pkg::NUM_AXES];
    logic signed [PROD_W-1:0]  qb_next [sti_pkg::NUM_AXES];
    logic signed [PROD_W-1:0]  ha_reg  [sti_pkg::NUM_AXES];
    logic signed [PROD_W-1:0]  hb_reg  [sti_pkg::NUM_AXES];
    logic signed [PROD_W-1:0]  qa_reg  [sti_pkg::NUM_AXES];
    logic signed [PROD_W-1:0]  qb_reg  [sti_pkg::NUM_AXES];
    logic signed [DIFF_W-1:0]  dir1_reg [sti_pkg::NUM_AXES];
    logic signed [DIFF_W-1:0]  e11_reg  [sti_pkg::NUM_AXES];
    logic signed [DIFF_W-1:0]  e21_reg  [sti_pkg::NUM_AXES];
    logic signed [DIFF_W-1:0]  s1_reg   [sti_pkg::NUM_AXES];
    logic signed [CROSS_W-1:0] h_next  [sti_pkg::NUM_AXES];
    logic signed [CROSS_W-1:0] q_next  [sti_pkg::NUM_AXES];
    logic signed [CROSS_W-1:0] h_reg   [sti_pkg::NUM_AXES];
    logic signed [CROSS_W-1:0] q_reg   [sti_pkg::NUM_AXES];
    logic signed [DIFF_W-1:0]  dir2_reg [sti_pkg::NUM_AXES];
    logic signed [DIFF_W-1:0]  e12_reg  [sti_pkg::NUM_AXES];
    logic signed [DIFF_W-1:0]  e22_reg  [sti_pkg::NUM_AXES];
    logic signed [DIFF_W-1:0]  s2_reg   [sti_pkg::NUM_AXES];

    // Each stage moves when empty or when the stage after it moves
    assign c2_advance = !c2_valid_reg || out_ready;
    assign c1_advance = !c1_valid_reg || c2_advance;
    assign in_ready   = c1_advance;

    // Stage 1: the twelve partial products of the two cross products
    for (genvar i = 0; i < sti_pkg::NUM_AXES; i++)
    begin : g_prod
        localparam int J = (i + 1) % sti_pkg::NUM_AXES;
        localparam int K = (i + 2) % sti_pkg::NUM_AXES;
        assign ha_next[i] = PROD_W'(dir_in[J]) * PROD_W'(e2_in[K]);
        assign hb_next[i] = PROD_W'(dir_in[K]) * PROD_W'(e2_in[J]);
        assign qa_next[i] = PROD_W'(s_in[J]) * PROD_W'(e1_in[K]);
        assign qb_next[i] = PROD_W'(s_in[K]) * PROD_W'(e1_in[J]);
    end

    // Stage 2: subtract the paired products
    always_comb
    begin
        for (int i = 0; i < sti_pkg::NUM_AXES; i++)
        begin
            h_next[i] = CROSS_W'(ha_reg[i]) - CROSS_W'(hb_reg[i]);
            q_next[i] = CROSS_W'(qa_reg[i]) - CROSS_W'(qb_reg[i]);
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_valid_reg <= 1'b0;
            c2_valid_reg <= 1'b0;
        end
        else
        begin
            if (c1_advance)
            begin
                c1_valid_reg <= in_valid;
            end
            if (c2_advance)
            begin
                c2_valid_reg <= c1_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (c1_advance)
        begin
            ha_reg   <= ha_next;
            hb_reg   <= hb_next;
            qa_reg   <= qa_next;
            qb_reg   <= qb_next;
            dir1_reg <= dir_in;
            e11_reg  <= e1_in;
            e21_reg  <= e2_in;
            s1_reg   <= s_in;
        end
        if (c2_advance)
        begin
            h_reg    <= h_next;
            q_reg    <= q_next;
            dir2_reg <= dir1_reg;
            e12_reg  <= e11_reg;
            e22_reg  <= e21_reg;
            s2_reg   <= s1_reg;
        end
    end

    assign out_valid = c2_valid_reg;
    assign dir_out   = dir2_reg;
    assign e1_out    = e12_reg;
    assign e2_out    = e22_reg;
    assign s_out     = s2_reg;
    assign h         = h_reg;
    assign q         = q_reg;

endmodule

`default_nettype wire

/* design/sti_dot.sv */
// Dot-product section: det, nu, nv and nt over three register stages.
// Each wide product is split into a low and a high partial product. Depends on sti_pkg.
`default_nettype none

module sti_dot #(
    parameter int  COORD_WIDTH = 24,
    localparam int DIFF_W      = COORD_WIDTH + 1,
    localparam int CROSS_W     = 2 * DIFF_W + 1,
    localparam int DOT_W       = DIFF_W + CROSS_W + 2
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output      logic                      in_ready,
    input  wire logic signed [DIFF_W-1:0]  dir [sti_pkg::NUM_AXES],
    input  wire logic signed [DIFF_W-1:0]  e1  [sti_pkg::NUM_AXES],
    input  wire logic signed [DIFF_W-1:0]  e2  [sti_pkg::NUM_AXES],
    input  wire logic signed [DIFF_W-1:0]  s   [sti_pkg::NUM_AXES],
    input  wire logic signed [CROSS_W-1:0] h   [sti_pkg::NUM_AXES],
    input  wire logic signed [CROSS_W-1:0] q   [sti_pkg::NUM_AXES],
    output      logic                      out_valid,
    input  wire logic                      out_ready,
    output      logic signed [DOT_W-1:0]   sums [sti_pkg::NUM_DOTS]
);

    // Low part of the cross term is unsigned, high part carries the sign
    localparam int LO_W    = COORD_WIDTH;
    localparam int HI_W    = CROSS_W - LO_W;
    localparam int LO_PW   = DIFF_W + LO_W + 1;
    localparam int HI_PW   = DIFF_W + HI_W;
    localparam int TERM_W  = DIFF_W + CROSS_W;

    logic                      d1_valid_reg;
    logic                      d2_valid_reg;
    logic                      d3_valid_reg;
    logic                      d1_advance;
    logic                      d2_advance;
    logic                      d3_advance;
    logic signed [DIFF_W-1:0]  lhs [sti_pkg::NUM_DOTS][sti_pkg::NUM_AXES];
    logic signed [CROSS_W-1:0] rhs [sti_pkg::NUM_DOTS][sti_pkg::NUM_AXES];
    logic signed [LO_PW-1:0]   lo_next [sti_pkg::NUM_DOTS][sti_pkg::NUM_AXES];
    logic signed [HI_PW-1:0]   hi_next [sti_pkg::NUM_DOTS][sti_pkg::NUM_AXES];
    logic signed [LO_PW-1:0]   lo_reg  [sti_pkg::NUM_DOTS][sti_pkg::NUM_AXES];
    logic signed [HI_PW-1:0]   hi_reg  [sti_pkg::NUM_DOTS][sti_pkg::NUM_AXES];
    logic signed [TERM_W-1:0]  term_next [sti_pkg::NUM_DOTS][sti_pkg::NUM_AXES];
    logic signed [TERM_W-1:0]  term_reg  [sti_pkg::NUM_DOTS][sti_pkg::NUM_AXES];
    logic signed [DOT_W-1:0]   sum_next [sti_pkg::NUM_DOTS];
    logic signed [DOT_W-1:0]   sum_reg  [sti_pkg::NUM_DOTS];

    assign d3_advance = !d3_valid_reg || out_ready;
    assign d2_advance = !d2_valid_reg || d3_advance;
    assign d1_advance = !d1_valid_reg || d2_advance;
    assign in_ready   = d1_advance;

    // Route operand pairs to the four lanes
    always_comb
    begin
        for (int i = 0; i < sti_pkg::NUM_AXES; i++)
        begin
            lhs[sti_pkg::DOT_DET][i] = e1[i];
            rhs[sti_pkg::DOT_DET][i] = h[i];
            lhs[sti_pkg::DOT_NU][i]  = s[i];
            rhs[sti_pkg::DOT_NU][i]  = h[i];
            lhs[sti_pkg::DOT_NV][i]  = dir[i];
            rhs[sti_pkg::DOT_NV][i]  = q[i];
            lhs[sti_pkg::DOT_NT][i]  = e2[i];
            rhs[sti_pkg::DOT_NT][i]  = q[i];
        end
    end

    // Stage 1: low and high partial products
    for (genvar d = 0; d < sti_pkg::NUM_DOTS; d++)
    begin : g_lane
        for (genvar i = 0; i < sti_pkg::NUM_AXES; i++)
        begin : g_axis
            assign lo_next[d][i] = LO_PW'(lhs[d][i])
                                   * LO_PW'($signed({1'b0, rhs[d][i][LO_W-1:0]}));
            assign hi_next[d][i] = HI_PW'(lhs[d][i])
                                   * HI_PW'($signed(rhs[d][i][CROSS_W-1:LO_W]));
        end
    end

    // Stage 2: rejoin partials into full products; stage 3: sum the axes
    always_comb
    begin
        for (int d = 0; d < sti_pkg::NUM_DOTS; d++)
        begin
            for (int i = 0; i < sti_pkg::NUM_AXES; i++)
            begin
                term_next[d][i] = (TERM_W'(hi_reg[d][i]) <<< LO_W) + TERM_W'(lo_reg[d][i]);
            end
            sum_next[d] = DOT_W'(term_reg[d][0]) + DOT_W'(term_reg[d][1])
                          + DOT_W'(term_reg[d][2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_valid_reg <= 1'b0;
            d2_valid_reg <= 1'b0;
            d3_valid_reg <= 1'b0;
        end
        else
        begin
            if (d1_advance)
            begin
                d1_valid_reg <= in_valid;
            end
            if (d2_advance)
            begin
                d2_valid_reg <= d1_valid_reg;
            end
            if (d3_advance)
            begin
                d3_valid_reg <= d2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (d1_advance)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
        if (d2_advance)
        begin
            term_reg <= term_next;
        end
        if (d3_advance)
        begin
            sum_reg <= sum_next;
        end
    end

    assign out_valid = d3_valid_reg;
    assign sums      = sum_reg;

endmodule

`default_nettype wire

/* design/sti_decide.sv */
// Decision section: sign correction against the determinant, range checks,
// and the result register. Depends on sti_pkg.
`default_nettype none

module sti_decide #(
    parameter int  COORD_WIDTH = 24,
    localparam int DOT_W       = 3 * COORD_WIDTH + 6
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output      logic                    in_ready,
    input  wire logic signed [DOT_W-1:0] sums [sti_pkg::NUM_DOTS],
    output      logic                    out_valid,
    input  wire logic                    out_ready,
    output      logic                    hit
);

    localparam int NORM_W = DOT_W + 1;
    localparam int SUM_W  = NORM_W + 1;

    logic                     e1_valid_reg;
    logic                     out_valid_reg;
    logic                     e1_advance;
    logic                     out_advance;
    logic                     flip;
    logic                     det_zero_next;
    logic                     det_zero_reg;
    logic signed [NORM_W-1:0] norm_next [sti_pkg::NUM_DOTS];
    logic signed [NORM_W-1:0] norm_reg  [sti_pkg::NUM_DOTS];
    logic signed [SUM_W-1:0]  uv_sum;
    logic                     hit_next;
    logic                     hit_reg;

    assign out_advance = !out_valid_reg || out_ready;
    assign e1_advance  = !e1_valid_reg || out_advance;
    assign in_ready    = e1_advance;

    // Negate all four values when the determinant is negative
    always_comb
    begin
        flip          = sums[sti_pkg::DOT_DET][DOT_W-1];
        det_zero_next = (sums[sti_pkg::DOT_DET] == '0);
        for (int d = 0; d < sti_pkg::NUM_DOTS; d++)
        begin
            norm_next[d] = flip ? -NORM_W'(sums[d]) : NORM_W'(sums[d]);
        end
    end

    // Hit needs 0 <= nu <= det, nv >= 0, nu + nv <= det and 0 < nt <= det
    always_comb
    begin
        uv_sum   = SUM_W'(norm_reg[sti_pkg::DOT_NU]) + SUM_W'(norm_reg[sti_pkg::DOT_NV]);
        hit_next = !det_zero_reg
                   && !norm_reg[sti_pkg::DOT_NU][NORM_W-1]
                   && (norm_reg[sti_pkg::DOT_NU] <= norm_reg[sti_pkg::DOT_DET])
                   && !norm_reg[sti_pkg::DOT_NV][NORM_W-1]
                   && (uv_sum <= SUM_W'(norm_reg[sti_pkg::DOT_DET]))
                   && !norm_reg[sti_pkg::DOT_NT][NORM_W-1]
                   && (norm_reg[sti_pkg::DOT_NT] != '0)
                   && (norm_reg[sti_pkg::DOT_NT] <= norm_reg[sti_pkg::DOT_DET]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (e1_advance)
            begin
                e1_valid_reg <= in_valid;
            end
            if (out_advance)
            begin
                out_valid_reg <= e1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (e1_advance)
        begin
            norm_reg     <= norm_next;
            det_zero_reg <= det_zero_next;
        end
        if (out_advance)
        begin
            hit_reg <= hit_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;

endmodule

`default_nettype wire

/* design/sti_checker.sv */
// Port-level checker for segment_triangle_intersect, attached by the bind below.
// Tracks tests in flight from the handshakes. Depends on sti_pkg.
`default_nettype none

module sti_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic item_valid,
    input wire logic item_ready,
    input wire logic item_operation,
    input wire logic result_valid,
    input wire logic result_ready,
    input wire logic result_hit
);

    localparam int CNT_W = $clog2(sti_pkg::STAGE_COUNT + 1) + 1;

    logic             test_beat;
    logic             result_beat;
    logic [CNT_W-1:0] pending_reg;
    logic [CNT_W-1:0] pending_next;

    assign test_beat   = item_valid && item_ready
                         && (sti_pkg::op_t'(item_operation) == sti_pkg::OP_TEST);
    assign result_beat = result_valid && result_ready;

    // Count tests accepted but not yet delivered
    always_comb
    begin
        pending_next = pending_reg;
        if (test_beat && !result_beat)
        begin
            pending_next = pending_reg + CNT_W'(1);
        end
        else if (!test_beat && result_beat)
        begin
            pending_next = pending_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // No result without a test in flight
    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (pending_reg != '0))
        else $error("result offered with no test in flight");

    // Tests in flight never exceed the pipeline depth
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= CNT_W'(sti_pkg::STAGE_COUNT))
        else $error("more tests in flight than pipeline stages");

    // An empty pipeline always takes an item
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg == '0) |-> item_ready)
        else $error("empty pipeline refused an item");

    // A stalled result holds its value
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> (result_valid && $stable(result_hit)))
        else $error("stalled result dropped or changed");

endmodule

bind segment_triangle_intersect sti_checker u_sti_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item.valid),
    .item_ready     (item.ready),
    .item_operation (item.operation),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .result_hit     (result.hit)
);

`default_nettype wire

/* tb/segment_triangle_intersect_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for segment_triangle_intersect: directed geometry table, then
// random segment loads and triangle tests under varied handshake pressure.
// Depends on sti_pkg, sti_item_if, sti_result_if and the segment_triangle_intersect RTL.

module segment_triangle_intersect_tb;

    localparam int COORD_WIDTH = 24;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_ITEMS = 112;
    localparam int REPORT_MAX  = 10;

    // Q12.12 unit and coordinate extremes
    localparam longint ONE  = 4096;
    localparam longint CMAX = 8388607;
    localparam longint CMIN = -8388608;

    typedef logic [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    typedef struct packed {
        sti_pkg::op_t operation;
        point_t       v0;
        point_t       v1;
        point_t       v2;
    } item_t;

    // How the hit bit of a test beat is known: from the predictor or typed in
    typedef enum logic [1:0] {
        VERDICT_PREDICT,
        VERDICT_MISS,
        VERDICT_HIT
    } verdict_t;

    typedef struct {
        item_t    stim;
        verdict_t verdict;
    } row_t;

    logic clk;
    logic rst_n;

    sti_item_if #(.COORD_WIDTH(COORD_WIDTH)) item_ch ();
    sti_result_if result_ch ();

    segment_triangle_intersect #(
        .COORD_WIDTH(COORD_WIDTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    // Stored segment as seen by the predictor, and as seen by the generator
    point_t   seg_start;
    point_t   seg_end;
    point_t   gen_start;
    point_t   gen_end;
    int       gen_scale;

    logic     expected_hits[$];
    verdict_t item_verdicts[$];
    row_t     directed_rows[$];

    int       mismatches;
    int       quiet_cycles;
    int       send_idle_pct;
    int       stall_pct;
    int       hold_request;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic longint lift(coord_t v);
        return longint'($signed(v));
    endfunction

    function automatic point_t pt(longint x, longint y, longint z);
        point_t p;
        p.x = coord_t'(x);
        p.y = coord_t'(y);
        p.z = coord_t'(z);
        return p;
    endfunction

    // Random point in [-2^k, 2^k] per axis; k of 23 or more covers every bit
    function automatic point_t rand_point(int k);
        if (k >= 23)
            return pt($urandom, $urandom, $urandom);
        return pt(longint'($urandom_range(0, 2 << k)) - (longint'(1) << k),
                  longint'($urandom_range(0, 2 << k)) - (longint'(1) << k),
                  longint'($urandom_range(0, 2 << k)) - (longint'(1) << k));
    endfunction

    // Exact crossing test of the stored segment against triangle a, b, c
    function automatic logic predict_crossing(point_t a, point_t b, point_t c);
        wide_t dx, dy, dz, e1x, e1y, e1z, e2x, e2y, e2z, sx, sy, sz;
        wide_t hx, hy, hz, qx, qy, qz, det, nu, nv, nt;
        dx  = wide_t'(lift(seg_end.x)) - wide_t'(lift(seg_start.x));
        dy  = wide_t'(lift(seg_end.y)) - wide_t'(lift(seg_start.y));
        dz  = wide_t'(lift(seg_end.z)) - wide_t'(lift(seg_start.z));
        e1x = wide_t'(lift(b.x)) - wide_t'(lift(a.x));
        e1y = wide_t'(lift(b.y)) - wide_t'(lift(a.y));
        e1z = wide_t'(lift(b.z)) - wide_t'(lift(a.z));
        e2x = wide_t'(lift(c.x)) - wide_t'(lift(a.x));
        e2y = wide_t'(lift(c.y)) - wide_t'(lift(a.y));
        e2z = wide_t'(lift(c.z)) - wide_t'(lift(a.z));
        sx  = wide_t'(lift(seg_start.x)) - wide_t'(lift(a.x));
        sy  = wide_t'(lift(seg_start.y)) - wide_t'(lift(a.y));
        sz  = wide_t'(lift(seg_start.z)) - wide_t'(lift(a.z));
        hx  = dy * e2z - dz * e2y;
        hy  = dz * e2x - dx * e2z;
        hz  = dx * e2y - dy * e2x;
        qx  = sy * e1z - sz * e1y;
        qy  = sz * e1x - sx * e1z;
        qz  = sx * e1y - sy * e1x;
        det = e1x * hx + e1y * hy + e1z * hz;
        nu  = sx * hx + sy * hy + sz * hz;
        nv  = dx * qx + dy * qy + dz * qz;
        nt  = e2x * qx + e2y * qy + e2z * qz;
        // Fold the sign of the determinant into all four terms
        if (det < 0)
        begin
            det = -det;
            nu  = -nu;
            nv  = -nv;
            nt  = -nt;
        end
        return (det != 0) && (nu >= 0) && (nu <= det) && (nv >= 0)
            && (nu + nv <= det) && (nt > 0) && (nt <= det);
    endfunction

    function automatic void add_row(sti_pkg::op_t op, point_t a, point_t b, point_t c,
                                    verdict_t v);
        row_t r;
        r.stim.operation = op;
        r.stim.v0        = a;
        r.stim.v1        = b;
        r.stim.v2        = c;
        r.verdict        = v;
        directed_rows.push_back(r);
    endfunction

    function automatic void report_mismatch(string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    // Some segment loads and random triangles; half the items are triangles built around a point of the segment
    task automatic make_random_item(output item_t it);
        int     pick;
        int     m;
        longint n;
        longint px, py, pz;
        point_t u1, u2, a, b, c;
        pick         = $urandom_range(0, 99);
        it.operation = sti_pkg::OP_TEST;
        it.v0        = rand_point(23);
        it.v1        = rand_point(23);
        it.v2        = rand_point(23);
        if (pick < 15)
        begin
            it.operation = sti_pkg::OP_LOAD;
            gen_scale    = ($urandom_range(0, 3) == 0) ? 23 : $urandom_range(2, 21);
            it.v0        = rand_point(gen_scale);
            it.v1        = rand_point(gen_scale);
            gen_start    = it.v0;
            gen_end      = it.v1;
        end
        else if (pick < 25)
        begin
            // keep the full-range triangle
        end
        else if (pick < 50)
        begin
            it.v0 = rand_point(gen_scale);
            it.v1 = rand_point(gen_scale);
            it.v2 = rand_point(gen_scale);
        end
        else
        begin
            // Put the triangle's centroid on the segment, end points included
            n  = $urandom_range(0, 256);
            px = lift(gen_start.x) + (((lift(gen_end.x) - lift(gen_start.x)) * n) >>> 8);
            py = lift(gen_start.y) + (((lift(gen_end.y) - lift(gen_start.y)) * n) >>> 8);
            pz = lift(gen_start.z) + (((lift(gen_end.z) - lift(gen_start.z)) * n) >>> 8);
            m  = $urandom_range(0, (gen_scale > 20) ? 20 : gen_scale);
            u1 = rand_point(m);
            u2 = rand_point(m);
            a  = pt(px + lift(u1.x), py + lift(u1.y), pz + lift(u1.z));
            b  = pt(px + lift(u2.x), py + lift(u2.y), pz + lift(u2.z));
            c  = pt(px - lift(u1.x) - lift(u2.x), py - lift(u1.y) - lift(u2.y),
                    pz - lift(u1.z) - lift(u2.z));
            it.v0 = a;
            // Flip the winding half of the time
            if ($urandom_range(0, 1) == 1)
            begin
                it.v1 = c;
                it.v2 = b;
            end
            else
            begin
                it.v1 = b;
                it.v2 = c;
            end
        end
    endtask

    // Offer one beat and hold it until it is accepted
    task automatic send_item(item_t it, verdict_t v);
        item_verdicts.push_back(v);
        item_ch.valid     <= 1'b1;
        item_ch.operation <= it.operation;
        item_ch.v0_x      <= it.v0.x;
        item_ch.v0_y      <= it.v0.y;
        item_ch.v0_z      <= it.v0.z;
        item_ch.v1_x      <= it.v1.x;
        item_ch.v1_y      <= it.v1.y;
        item_ch.v1_z      <= it.v1.z;
        item_ch.v2_x      <= it.v2.x;
        item_ch.v2_y      <= it.v2.y;
        item_ch.v2_z      <= it.v2.z;
        do
            @(posedge clk);
        while (!item_ch.ready);
    endtask

    task automatic sender_gap();
        int n;
        n = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            n++;
        if (n > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Drop valid and wait until every expected hit bit has come back
    task automatic drain_results();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_hits.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    initial
    begin : receiver
        int hold_left;
        hold_left       = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Track accepted beats on both channels and check each hit bit
    always @(posedge clk)
    begin : scoreboard
        verdict_t v;
        logic     want;
        item_t    got;
        if (rst_n)
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                v             = item_verdicts.pop_front();
                got.operation = sti_pkg::op_t'(item_ch.operation);
                got.v0        = {item_ch.v0_x, item_ch.v0_y, item_ch.v0_z};
                got.v1        = {item_ch.v1_x, item_ch.v1_y, item_ch.v1_z};
                got.v2        = {item_ch.v2_x, item_ch.v2_y, item_ch.v2_z};
                if (got.operation == sti_pkg::OP_LOAD)
                begin
                    seg_start = got.v0;
                    seg_end   = got.v1;
                end
                else
                begin
                    case (v)
                        VERDICT_MISS: want = 1'b0;
                        VERDICT_HIT:  want = 1'b1;
                        default:      want = predict_crossing(got.v0, got.v1, got.v2);
                    endcase
                    expected_hits.push_back(want);
                end
            end
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_hits.size() == 0)
                    report_mismatch($sformatf("result beat hit=%0b with none expected",
                                              result_ch.hit));
                else
                begin
                    want = expected_hits.pop_front();
                    if (result_ch.hit !== want)
                        report_mismatch($sformatf("hit expected %0b, got %0b",
                                                  want, result_ch.hit));
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves on either channel for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("segment_triangle_intersect_tb: errors");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : main
        item_t it;
        point_t tri_a, tri_b, tri_c;
        int ph;
        int i;

        mismatches        = 0;
        quiet_cycles      = 0;
        send_idle_pct     = 0;
        stall_pct         = 0;
        hold_request      = 0;
        seg_start         = '0;
        seg_end           = '0;
        gen_start         = '0;
        gen_end           = '0;
        gen_scale         = 2;
        rst_n             = 1'b0;
        item_ch.valid     = 1'b0;
        item_ch.operation = sti_pkg::OP_LOAD;
        item_ch.v0_x      = '0;
        item_ch.v0_y      = '0;
        item_ch.v0_z      = '0;
        item_ch.v1_x      = '0;
        item_ch.v1_y      = '0;
        item_ch.v1_z      = '0;
        item_ch.v2_x      = '0;
        item_ch.v2_y      = '0;
        item_ch.v2_z      = '0;

        // Unit triangle in the z = 0 plane, with the z axis passing through it
        tri_a = pt(-ONE, -ONE, 0);
        tri_b = pt(ONE, -ONE, 0);
        tri_c = pt(0, ONE, 0);

        // Test before any load: the reset segment has zero length
        add_row(sti_pkg::OP_TEST, tri_a, tri_b, tri_c, VERDICT_MISS);
        add_row(sti_pkg::OP_LOAD, pt(0, 0, -ONE), pt(0, 0, ONE), pt(CMAX, CMIN, CMAX),
                VERDICT_PREDICT);
        add_row(sti_pkg::OP_TEST, tri_a, tri_b, tri_c, VERDICT_PREDICT);
        // Reversed winding gives a positive determinant; the winding above gives a negative one
        add_row(sti_pkg::OP_TEST, tri_a, tri_c, tri_b, VERDICT_PREDICT);
        // Degenerate triangles: repeated vertex, collinear vertices
        add_row(sti_pkg::OP_TEST, tri_a, tri_a, tri_c, VERDICT_MISS);
        add_row(sti_pkg::OP_TEST, pt(0, 0, 0), pt(ONE, ONE, 0), pt(2 * ONE, 2 * ONE, 0),
                VERDICT_MISS);
        // Segment parallel to the plane, then lying in it
        add_row(sti_pkg::OP_LOAD, pt(-ONE, 0, ONE), pt(ONE, 0, ONE), pt(0, 0, 0),
                VERDICT_PREDICT);
        add_row(sti_pkg::OP_TEST, tri_a, tri_b, tri_c, VERDICT_MISS);
        add_row(sti_pkg::OP_LOAD, pt(-ONE / 2, 0, 0), pt(ONE / 2, 0, 0), pt(0, 0, 0),
                VERDICT_PREDICT);
        add_row(sti_pkg::OP_TEST, tri_a, tri_b, tri_c, VERDICT_MISS);
        // Zero-length segment
        add_row(sti_pkg::OP_LOAD, pt(ONE, ONE, ONE), pt(ONE, ONE, ONE), pt(0, 0, 0),
                VERDICT_PREDICT);
        add_row(sti_pkg::OP_TEST, tri_a, tri_b, tri_c, VERDICT_MISS);
        // Crossing on an edge, then on a vertex
        add_row(sti_pkg::OP_LOAD, pt(0, -ONE, -ONE), pt(0, -ONE, ONE), pt(0, 0, 0),
                VERDICT_PREDICT);
        add_row(sti_pkg::OP_TEST, tri_a, tri_b, tri_c, VERDICT_PREDICT);
        add_row(sti_pkg::OP_LOAD, pt(ONE, -ONE, -ONE), pt(ONE, -ONE, ONE), pt(0, 0, 0),
                VERDICT_PREDICT);
        add_row(sti_pkg::OP_TEST, tri_a, tri_b, tri_c, VERDICT_PREDICT);
        // Segment end on the triangle, then segment start on it
        add_row(sti_pkg::OP_LOAD, pt(0, 0, -ONE), pt(0, 0, 0), pt(0, 0, 0), VERDICT_PREDICT);
        add_row(sti_pkg::OP_TEST, tri_a, tri_b, tri_c, VERDICT_PREDICT);
        add_row(sti_pkg::OP_LOAD, pt(0, 0, 0), pt(0, 0, ONE), pt(0, 0, 0), VERDICT_PREDICT);
        add_row(sti_pkg::OP_TEST, tri_a, tri_b, tri_c, VERDICT_PREDICT);
        // Coordinate extremes
        add_row(sti_pkg::OP_LOAD, pt(0, 0, CMIN), pt(0, 0, CMAX), pt(CMIN, CMIN, CMIN),
                VERDICT_PREDICT);
        add_row(sti_pkg::OP_TEST, pt(CMIN, CMIN, 0), pt(CMAX, CMIN, 0), pt(0, CMAX, 0),
                VERDICT_PREDICT);
        add_row(sti_pkg::OP_TEST, pt(CMAX, CMIN, CMAX), pt(CMIN, CMAX, CMIN),
                pt(CMAX, CMAX, CMIN), VERDICT_PREDICT);
        add_row(sti_pkg::OP_LOAD, pt(CMIN, CMIN, CMIN), pt(CMAX, CMAX, CMAX), pt(-1, -1, -1),
                VERDICT_PREDICT);
        add_row(sti_pkg::OP_TEST, pt(CMAX, CMAX, CMAX), pt(CMAX, CMAX, CMAX),
                pt(CMAX, CMAX, CMAX), VERDICT_MISS);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table back to back
        foreach (directed_rows[r])
            send_item(directed_rows[r].stim, directed_rows[r].verdict);
        drain_results();

        // Generator starts from the last directed segment
        gen_start = seg_start;
        gen_end   = seg_end;
        gen_scale = 23;

        // Random phases: no idling, idle sender, stalling receiver, both
        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 60;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 60;
                end
                default:
                begin
                    send_idle_pct = 22;
                    stall_pct     = 22;
                end
            endcase
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                // Long receiver hold-off while beats keep coming, to back up the pipe
                if (ph == 0 && i == 30)
                    hold_request = 64;
                make_random_item(it);
                send_item(it, VERDICT_PREDICT);
                if (i == PHASE_ITEMS - 1)
                    drain_results();
                else
                    sender_gap();
            end
        end

        // Let any stray beat show up before the verdict
        repeat (3 * sti_pkg::STAGE_COUNT) @(posedge clk);
        if (expected_hits.size() != 0)
            report_mismatch($sformatf("%0d hit bits never arrived", expected_hits.size()));

        if (mismatches == 0)
            $display("segment_triangle_intersect_tb: clean");
        else
            $display("segment_triangle_intersect_tb: errors");
        $finish;
    end

endmodule
